FILE: design/ipm_pkg.sv
// ----------------------------------------------------------------------------
// ipm_pkg: shared types and constants for the IPv4 prefix match table
// Request opcodes, field widths and the record that moves along the cell chain.
// ----------------------------------------------------------------------------
package ipm_pkg;

   localparam int TableDepthDefault = 64;
   localparam int IndexWidth        = 6;
   localparam int AddrWidth         = 32;
   localparam int LenWidth          = 6;
   localparam int LimitWidth        = 7;
   localparam logic [LenWidth-1:0] MaxPrefixLen = LenWidth'(AddrWidth);

   typedef enum logic [0:0] {
      OP_WRITE  = 1'b0,
      OP_LOOKUP = 1'b1
   } opcode_type;

   typedef struct packed {
      logic                  valid;
      opcode_type            opcode;
      logic [IndexWidth-1:0] entry_index;
      logic [AddrWidth-1:0]  ip_address;
      logic [LenWidth-1:0]   prefix_length;
      logic [IndexWidth-1:0] matched_index;
      logic                  hit;
   } chain_type;

endpackage

FILE: design/ipm_cell.sv
// ----------------------------------------------------------------------------
// ipm_cell: one table slot of the prefix match chain
// Holds one prefix entry, captures writes aimed at its slot and updates the
// match result of each lookup request as it passes by.
// ----------------------------------------------------------------------------
module ipm_cell
   import ipm_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic [LimitWidth-1:0] limit,
   input  chain_type             chain_in,
   output chain_type             chain_out
);

   localparam logic [31:0]           CellPos  = 32'(CELL_INDEX);
   localparam logic [IndexWidth-1:0] CellSlot = IndexWidth'(CELL_INDEX);
   localparam bit                    Writable = CELL_INDEX < (1 << IndexWidth);

   logic [AddrWidth-1:0] addr_ff;
   logic [LenWidth-1:0]  len_ff;
   chain_type            chain_ff;
   chain_type            chain_in_c;
   logic [AddrWidth-1:0] mask;
   logic                 in_use;
   logic                 write_hit;
   logic [LenWidth-1:0]  len_sat;

   always_comb begin
      mask      = ~({AddrWidth{1'b1}} >> len_ff);
      in_use    = {{(32-LimitWidth){1'b0}}, limit} > CellPos;
      write_hit = Writable && chain_in.valid && (chain_in.opcode == OP_WRITE) &&
                  (chain_in.entry_index == CellSlot);
      len_sat   = (chain_in.prefix_length > MaxPrefixLen) ? MaxPrefixLen :
                  chain_in.prefix_length;
      chain_in_c = chain_in;
      if (chain_in.valid && (chain_in.opcode == OP_LOOKUP) && in_use &&
          (((addr_ff ^ chain_in.ip_address) & mask) == '0)) begin
         chain_in_c.matched_index = CellSlot;
         chain_in_c.hit           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && write_hit) begin
         addr_ff <= chain_in.ip_address;
         len_ff  <= len_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff.valid <= 1'b0;
      end else if (enable) begin
         chain_ff.valid <= chain_in_c.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         chain_ff.opcode        <= chain_in_c.opcode;
         chain_ff.entry_index   <= chain_in_c.entry_index;
         chain_ff.ip_address    <= chain_in_c.ip_address;
         chain_ff.prefix_length <= chain_in_c.prefix_length;
         chain_ff.matched_index <= chain_in_c.matched_index;
         chain_ff.hit           <= chain_in_c.hit;
      end
   end

   assign chain_out = chain_ff;

endmodule

FILE: design/ipv4_prefix_match_table.sv
// Each request is registered in every cell of the chain in turn, then in the output register.
// Throughput: one request per cycle while req_stall is low; every request walks
// the chain of cells, one cell per cycle, and a held response stalls the whole chain.
// Reset clears the request valids, the response valid and entries_in_use.
// Table contents are not cleared and stay undefined until written.
// ----------------------------------------------------------------------------
// ipv4_prefix_match_table: IPv4 prefix table with last-match lookup
// A row of cells, one per slot; writes and lookups pass in order, and each
// lookup reports the highest matching slot among the entries in use.
// ----------------------------------------------------------------------------
module ipv4_prefix_match_table
   import ipm_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [IndexWidth-1:0] req_entry_index,
   input  logic [AddrWidth-1:0]  req_ip_address,
   input  logic [LenWidth-1:0]   req_prefix_length,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [IndexWidth-1:0] rsp_matched_index,
   output logic                  rsp_hit,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LimitWidth-1:0] csr_entries_in_use
);

   chain_type             link [TABLE_DEPTH+1];
   chain_type             tail;
   logic                  enable;
   logic                  tail_lookup;
   logic [LimitWidth-1:0] limit_ff;
   logic                  rsp_valid_ff;
   logic [IndexWidth-1:0] rsp_index_ff;
   logic                  rsp_hit_ff;

   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;
   assign csr_ready = 1'b1;

   always_comb begin
      link[0].valid         = req_valid;
      link[0].opcode        = opcode_type'(req_opcode);
      link[0].entry_index   = req_entry_index;
      link[0].ip_address    = req_ip_address;
      link[0].prefix_length = req_prefix_length;
      link[0].matched_index = '0;
      link[0].hit           = 1'b0;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ipm_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .limit    (limit_ff),
         .chain_in (link[i]),
         .chain_out(link[i+1])
      );
   end

   assign tail        = link[TABLE_DEPTH];
   assign tail_lookup = tail.valid && (tail.opcode == OP_LOOKUP);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_entries_in_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= tail_lookup;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_index_ff <= tail.matched_index;
         rsp_hit_ff   <= tail.hit;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched_index = rsp_index_ff;
   assign rsp_hit           = rsp_hit_ff;

   a_miss_index_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_index_ff == '0)
      else $error("miss with nonzero index");

   a_index_in_table : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 32'(rsp_index_ff) < 32'(TABLE_DEPTH))
      else $error("matched index beyond table");

   a_tail_to_rsp : assert property (@(posedge clock) disable iff (reset)
      enable && tail_lookup |=> rsp_valid_ff)
      else $error("lookup lost at chain tail");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

endmodule
